// ----- rtl/rss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the 3x3 sharpen filter
// Word layouts of both channels, frame limits, kernel constants and the
// clamping of the frame size registers.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Frame limits
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int MIN_DIM     = 2;
  localparam int RESET_DIM   = 512;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W    = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W      = $clog2(MAX_HEIGHT);

  // Kernel
  localparam int SIDE        = 3;
  localparam int TAPS        = SIDE * SIDE;
  localparam int CENTRE      = TAPS / 2;
  localparam int CENTRE_GAIN = 9;
  localparam int LANES       = 3;

  // Sample and accumulator widths
  localparam int CH_W        = 8;
  localparam int CH_MAX      = 255;
  localparam int PIX_W       = LANES * CH_W;
  localparam int LINE_W      = 2 * PIX_W;
  localparam int GAIN_W      = CH_W + 4;
  localparam int SUM_W       = CH_W + 3;
  localparam int ACC_W       = GAIN_W + 1;

  // Result queue
  localparam int OUTQ_DEPTH  = 4;
  localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [CH_W-1:0]           chan_t;
  typedef logic [PIX_W-1:0]          pixel_t;
  typedef logic [TAPS-1:0][CH_W-1:0] patch_t;

  typedef struct packed {
    logic  req_type;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } req_word_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic  frame_last;
  } res_word_t;

  // Which neighbour rows and columns lie inside the frame
  typedef struct packed {
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
  } nb_mask_t;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] d);
    logic [WIDTH_W-1:0] r;
    if (int'(d) < MIN_DIM) r = WIDTH_W'(MIN_DIM);
    else if (int'(d) > MAX_WIDTH) r = WIDTH_W'(MAX_WIDTH);
    else r = WIDTH_W'(d);
    return r;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] d);
    logic [HEIGHT_W-1:0] r;
    if (int'(d) < MIN_DIM) r = HEIGHT_W'(MIN_DIM);
    else if (int'(d) > MAX_HEIGHT) r = HEIGHT_W'(MAX_HEIGHT);
    else r = HEIGHT_W'(d);
    return r;
  endfunction

endpackage

// ----- rtl/rss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rss_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_lane: one colour channel of the sharpen kernel
// Nine times the centre minus the in-frame neighbours, saturated to 0..255.
// ----------------------------------------------------------------------------
module rss_lane (
  input  rss_pkg::patch_t   patch,
  input  rss_pkg::nb_mask_t mask,
  output rss_pkg::chan_t    result
);
  import rss_pkg::*;

  logic [SUM_W-1:0]        nsum;
  logic [GAIN_W-1:0]       centre_gain;
  logic signed [ACC_W-1:0] acc;

  // Sum the neighbours that lie inside the frame
  always_comb begin
    logic row_ok;
    logic col_ok;
    nsum = '0;
    for (int r = 0; r < SIDE; r++) begin
      row_ok = (r == 0) ? mask.top_ok : ((r == SIDE - 1) ? mask.bottom_ok : 1'b1);
      for (int c = 0; c < SIDE; c++) begin
        col_ok = (c == 0) ? mask.left_ok : ((c == SIDE - 1) ? mask.right_ok : 1'b1);
        if ((r * SIDE + c != CENTRE) && row_ok && col_ok) begin
          nsum = nsum + SUM_W'(patch[r * SIDE + c]);
        end
      end
    end
  end

  // Weight the centre and take the difference
  assign centre_gain = GAIN_W'(CENTRE_GAIN) * GAIN_W'(patch[CENTRE]);
  assign acc = $signed({1'b0, centre_gain}) - $signed({2'b00, nsum});

  // Saturate to the sample range
  always_comb begin
    if (acc < 0) begin
      result = '0;
    end else if (acc > $signed(ACC_W'(CH_MAX))) begin
      result = CH_W'(CH_MAX);
    end else begin
      result = acc[CH_W-1:0];
    end
  end

endmodule

// ----- rtl/rss_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_outq: result queue
// Small register queue that holds finished result words while the output
// side stalls; the head is presented directly on the output.
// ----------------------------------------------------------------------------
module rss_outq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  rss_pkg::res_word_t                push_word,
  input  logic                              pop,
  output rss_pkg::res_word_t                head_word,
  output logic                              head_valid,
  output logic [rss_pkg::OUTQ_CNT_W-1:0]    fill
);
  import rss_pkg::*;

  res_word_t               entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wr_ptr;
  logic [OUTQ_PTR_W-1:0]   rd_ptr;
  logic [OUTQ_CNT_W-1:0]   fill_next;

  assign head_valid = (fill != '0);
  assign head_word  = entries[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) fill_next = fill + OUTQ_CNT_W'(1);
    else if (pop && !push) fill_next = fill - OUTQ_CNT_W'(1);
  end

  // Advance the pointers and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == OUTQ_DEPTH - 1) ? '0 : wr_ptr + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == OUTQ_DEPTH - 1) ? '0 : rd_ptr + OUTQ_PTR_W'(1);
      end
      fill <= fill_next;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

// ----- rtl/rgb_sharpen_3x3_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_top: streaming 3x3 sharpen filter for colour pixels
//
//   channel   signals                        word
//   request   req_valid / req_stall          req_word_t (pixel or flush tick)
//   result    res_valid / res_stall          res_word_t (sharpened pixel)
//   config    cfg_wr_en / cfg_index          cfg_data (frame width, height)
//
// One word per clock is taken when the result side keeps up. The word that
// completes a neighbourhood passes the registered line store read, the
// registered window shift, then the three colour lanes, into the queue.
// Stall rises once the four-entry result queue plus the two words in flight
// could overfill it. Reset clears counters and pipeline valids and loads
// the frame size registers; the line stores need no clearing pass, as every
// neighbour outside the frame is masked to zero.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  rss_pkg::req_word_t                 req_word,
  output logic                               res_valid,
  input  logic                               res_stall,
  output rss_pkg::res_word_t                 res_word,
  input  logic                               cfg_wr_en,
  input  logic [rss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rss_pkg::*;

  // Configuration and position counters
  logic [WIDTH_W-1:0]    frame_width;
  logic [HEIGHT_W-1:0]   frame_height;
  logic [COL_W-1:0]      in_column;
  logic [HEIGHT_W-1:0]   in_row;
  logic [COL_W-1:0]      out_col;
  logic [OROW_W-1:0]     out_row;

  // Input decode
  logic                  accept;
  logic                  in_frame;
  logic                  step;
  logic                  emit0;
  logic                  last0;
  logic                  col_last;
  logic                  ocol_last;
  logic                  orow_last;
  pixel_t                pix0;
  nb_mask_t              mask0;

  // Pipeline stages
  logic                  v1;
  logic [COL_W-1:0]      x1;
  pixel_t                pix1;
  logic                  emit1;
  logic                  last1;
  nb_mask_t              mask1;
  logic                  v2;
  logic                  last2;
  nb_mask_t              mask2;

  logic [LINE_W-1:0]     line_rd;
  pixel_t                new_col [SIDE];
  pixel_t                window [TAPS];
  patch_t                patch [LANES];
  chan_t                 lane_res [LANES];
  res_word_t             merged;
  logic [OUTQ_CNT_W-1:0] q_fill;
  logic [OUTQ_CNT_W:0]   committed;

  // Decode the incoming word against the frame position
  assign accept    = req_valid && !req_stall;
  assign in_frame  = (in_row < frame_height);
  assign step      = accept && !(in_frame && req_word.req_type);
  assign pix0      = in_frame ? {req_word.red_in, req_word.green_in, req_word.blue_in} : '0;
  assign col_last  = (WIDTH_W'(in_column) == frame_width - WIDTH_W'(1));
  assign emit0     = (in_row > HEIGHT_W'(1)) ||
                     ((in_row == HEIGHT_W'(1)) && (in_column != '0));
  assign ocol_last = (WIDTH_W'(out_col) == frame_width - WIDTH_W'(1));
  assign orow_last = (HEIGHT_W'(out_row) == frame_height - HEIGHT_W'(1));
  assign last0     = ocol_last && orow_last;
  assign mask0     = '{top_ok:    (out_row != '0),
                       bottom_ok: !orow_last,
                       left_ok:   (out_col != '0),
                       right_ok:  !ocol_last};

  // Hold the frame size; advance input and output positions
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= clamp_width(CFG_DATA_W'(RESET_DIM));
      frame_height <= clamp_height(CFG_DATA_W'(RESET_DIM));
      in_column    <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= clamp_width(cfg_data);
        REG_FRAME_HEIGHT: frame_height <= clamp_height(cfg_data);
        default: ;
      endcase
      in_column <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (step) begin
      if (emit0 && last0) begin
        in_column <= '0;
        in_row    <= '0;
        out_col   <= '0;
        out_row   <= '0;
      end else begin
        if (col_last) begin
          in_column <= '0;
          in_row    <= in_row + HEIGHT_W'(1);
        end else begin
          in_column <= in_column + COL_W'(1);
        end
        if (emit0) begin
          if (ocol_last) begin
            out_col <= '0;
            out_row <= out_row + OROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  // Upper and middle line stores share one word per column
  rss_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (v1),
    .wr_addr (x1),
    .wr_data ({line_rd[PIX_W-1:0], pix1}),
    .rd_en   (step),
    .rd_addr (in_column),
    .rd_data (line_rd)
  );

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= step;
      v2 <= v1 && emit1;
    end
  end

  // Carry the word's context alongside the line store read
  always_ff @(posedge clk) begin
    x1    <= in_column;
    pix1  <= pix0;
    emit1 <= emit0;
    last1 <= last0;
    mask1 <= mask0;
    last2 <= last1;
    mask2 <= mask1;
  end

  assign new_col[0] = line_rd[LINE_W-1:PIX_W];
  assign new_col[1] = line_rd[PIX_W-1:0];
  assign new_col[2] = pix1;

  // Shift the window left and load the new column
  always_ff @(posedge clk) begin
    if (v1) begin
      for (int r = 0; r < SIDE; r++) begin
        for (int c = 0; c < SIDE - 1; c++) begin
          window[r * SIDE + c] <= window[r * SIDE + c + 1];
        end
        window[r * SIDE + SIDE - 1] <= new_col[r];
      end
    end
  end

  // Split the window into one patch per colour
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int i = 0; i < TAPS; i++) begin
        patch[l][i] = window[i][(LANES - 1 - l) * CH_W +: CH_W];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rss_lane u_lane (
      .patch  (patch[g]),
      .mask   (mask2),
      .result (lane_res[g])
    );
  end

  // Merge the lane results into one result word
  assign merged = '{red_out:    lane_res[0],
                    green_out:  lane_res[1],
                    blue_out:   lane_res[2],
                    frame_last: last2};

  rss_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (v2),
    .push_word  (merged),
    .pop        (res_valid && !res_stall),
    .head_word  (res_word),
    .head_valid (res_valid),
    .fill       (q_fill)
  );

  // Stall while queued plus in-flight words could overfill the queue
  assign committed = (OUTQ_CNT_W + 1)'(q_fill) + (OUTQ_CNT_W + 1)'(v1)
                   + (OUTQ_CNT_W + 1)'(v2);
  assign req_stall = (committed >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));

endmodule

// ----- rtl/rss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_checker: port-level checks on the sharpen filter
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module rss_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  input  logic                               req_stall,
  input  logic                               res_valid,
  input  logic                               res_stall,
  input  rss_pkg::res_word_t                 res_word
);
  import rss_pkg::*;

  // A stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("result word changed while stalled");

  // With the result queue empty there is always room for a request
  a_room_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("request stalled with nothing queued");

  // A result only appears as the outcome of an accepted request
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_valid && !req_stall, 3))
    else $error("result appeared without a request word");

endmodule

bind rgb_sharpen_3x3_top rss_checker u_rss_checker (.*);
